/* rtl/core/sosc_pkg.sv */
// Package for the soft offset S-curve 4D block: configuration and queue types,
// register indexes, sizing constants and the 32-bit saturation helper.
// No dependencies.
`default_nettype none
package sosc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_AXES      = 4;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);
	localparam int PADDR_W       = 6;
	localparam int PDATA_W       = 64;

	// register indexes, byte address 8*i
	typedef enum logic [2:0] {
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_OFFSET_Z,
		REG_OFFSET_W,
		REG_GAIN,
		REG_CONTROL_BITS,
		REG_COLOR_WEIGHTS
	} reg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [NUM_AXES-1:0][31:0] offset;
		logic [31:0]               gain;
		logic [NUM_AXES-1:0]       axis_en;
		logic                      color_en;
		logic                      color_mode;
		logic [NUM_AXES-1:0][15:0] weight;
	} cfg_t;

	// classified item held in the queue
	typedef struct packed {
		logic [NUM_AXES-1:0][31:0] pos;    // w already fixed up
		logic [NUM_AXES-1:0][31:0] mag;    // |pos|
		logic [NUM_AXES-1:0]       is_zero;
		logic                      w_zero; // w arrived as zero
		logic [31:0]               color;
	} item_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/sosc_cfg.sv */
// Configuration register file behind the APB-style port.
// Depends on sosc_pkg.
`default_nettype none
module sosc_cfg #(
	parameter int FRAC_BITS = sosc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sosc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sosc_pkg::PDATA_W-1:0] pwdata,
	output logic      [sosc_pkg::PDATA_W-1:0] prdata,
	output sosc_pkg::cfg_t                    cfg
);
	import sosc_pkg::*;

	logic [NUM_AXES-1:0][31:0] offset_q;
	logic [31:0]               gain_q;
	logic [5:0]                ctrl_q;
	logic [63:0]               wgt_q;
	logic                      wr_en;
	reg_idx_t                  idx;

	assign idx   = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			gain_q   <= 32'(64'd1 << FRAC_BITS);
			ctrl_q   <= 6'd1;
			wgt_q    <= '0;
		end else if (wr_en) begin
			case (paddr[PADDR_W-1:3])
				REG_OFFSET_X:      offset_q[0] <= pwdata[31:0];
				REG_OFFSET_Y:      offset_q[1] <= pwdata[31:0];
				REG_OFFSET_Z:      offset_q[2] <= pwdata[31:0];
				REG_OFFSET_W:      offset_q[3] <= pwdata[31:0];
				REG_GAIN:          gain_q      <= pwdata[31:0];
				REG_CONTROL_BITS:  ctrl_q      <= pwdata[5:0];
				REG_COLOR_WEIGHTS: wgt_q       <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_OFFSET_X:      prdata = {32'd0, offset_q[0]};
			REG_OFFSET_Y:      prdata = {32'd0, offset_q[1]};
			REG_OFFSET_Z:      prdata = {32'd0, offset_q[2]};
			REG_OFFSET_W:      prdata = {32'd0, offset_q[3]};
			REG_GAIN:          prdata = {32'd0, gain_q};
			REG_CONTROL_BITS:  prdata = {58'd0, ctrl_q};
			REG_COLOR_WEIGHTS: prdata = wgt_q;
			default:           prdata = '0;
		endcase
	end

	assign cfg.offset     = offset_q;
	assign cfg.gain       = gain_q;
	assign cfg.axis_en    = ctrl_q[3:0];
	assign cfg.color_en   = ctrl_q[4];
	assign cfg.color_mode = ctrl_q[5];
	assign cfg.weight     = wgt_q;

endmodule
`default_nettype wire

/* rtl/core/sosc_front.sv */
// Front end: accepts points, fixes a zero w and classifies each axis.
// Depends on sosc_pkg.
`default_nettype none
module sosc_front (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] pos_w,
	input  wire logic [31:0] color_in,
	input  wire logic        q_full,
	output logic             q_push,
	output sosc_pkg::item_t  q_item
);
	import sosc_pkg::*;

	logic [NUM_AXES-1:0][31:0] p;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// classification
	always_comb begin
		p[0] = pos_x;
		p[1] = pos_y;
		p[2] = pos_z;
		p[3] = (pos_w == 32'd0) ? 32'hffffffff : pos_w;
		q_item.pos    = p;
		q_item.w_zero = (pos_w == 32'd0);
		q_item.color  = color_in;
		for (int k = 0; k < NUM_AXES; k++) begin
			q_item.mag[k]     = p[k][31] ? (32'd0 - p[k]) : p[k];
			q_item.is_zero[k] = (p[k] == 32'd0);
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sosc_fifo.sv */
// Short queue between front and back ends.
// Depends on sosc_pkg.
`default_nettype none
module sosc_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sosc_pkg::item_t din,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output sosc_pkg::item_t      dout
);
	import sosc_pkg::*;

	item_t              mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full      = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sosc_back.sv */
// Back end: squares, pipelined restoring divider, gain multiplies and color update.
// Depends on sosc_pkg.
`default_nettype none
module sosc_back #(
	parameter int FRAC_BITS = sosc_pkg::FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sosc_pkg::cfg_t  cfg,
	input  wire sosc_pkg::item_t din,
	input  wire logic            din_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [31:0]          new_x,
	output logic [31:0]          new_y,
	output logic [31:0]          new_z,
	output logic [31:0]          new_w,
	output logic [31:0]          color_out
);
	import sosc_pkg::*;

	localparam int QW  = FRAC_BITS + 1;    // quotient bits
	localparam int DST = FRAC_BITS + 1;    // divider stages
	localparam int NST = 2 + DST + 6;      // total stages
	localparam int PW  = 32 + QW + 1;      // c*q width

	logic           adv;
	logic [NST-1:0] vld_q;

	// S1 / S2
	logic signed [31:0] v_s1 [NUM_AXES];
	logic [63:0]        num_s1 [NUM_AXES];
	logic [63:0]        acsq_s1 [NUM_AXES];
	logic [NUM_AXES-1:0] vz_s1;
	logic [31:0]        color_s1;
	logic               wz_s1;
	logic signed [31:0] v_s2 [NUM_AXES];
	logic [63:0]        num_s2 [NUM_AXES];
	logic [63:0]        den_s2 [NUM_AXES];
	logic [NUM_AXES-1:0] zf_s2;
	logic [31:0]        color_s2;
	logic               wz_s2;

	// divider stages
	logic [63:0]        rem_d [DST][NUM_AXES];
	logic [QW-1:0]      q_d   [DST][NUM_AXES];
	logic [63:0]        den_d [DST][NUM_AXES];
	logic signed [31:0] v_d   [DST][NUM_AXES];
	logic [NUM_AXES-1:0] zf_d [DST];
	logic [31:0]        color_d [DST];
	logic               wz_d [DST];
	logic [63:0]        rem_n [DST][NUM_AXES];
	logic [QW-1:0]      q_n   [DST][NUM_AXES];

	// multiply and color stages
	logic signed [31:0] t_m1 [NUM_AXES];
	logic signed [31:0] v_m1 [NUM_AXES];
	logic [NUM_AXES-1:0] zf_m1;
	logic [31:0]        color_m1;
	logic               wz_m1;
	logic signed [31:0] m_m2 [NUM_AXES];
	logic signed [31:0] v_m2 [NUM_AXES];
	logic [NUM_AXES-1:0] zf_m2;
	logic [31:0]        color_m2;
	logic               wz_m2;
	logic signed [31:0] off_m3 [NUM_AXES];
	logic signed [31:0] nv_m3 [NUM_AXES];
	logic signed [31:0] orig_m3 [NUM_AXES];
	logic [31:0]        color_m3;
	logic signed [31:0] op_c1 [NUM_AXES];
	logic [NUM_AXES-1:0] inc_c1;
	logic signed [31:0] nv_c1 [NUM_AXES];
	logic [31:0]        color_c1;
	logic signed [31:0] term_c2 [NUM_AXES];
	logic signed [31:0] nv_c2 [NUM_AXES];
	logic [31:0]        color_c2;
	logic [31:0]        nv_o_q [NUM_AXES];
	logic [31:0]        color_o_q;

	logic signed [31:0] t_n [NUM_AXES];
	logic signed [31:0] m_n [NUM_AXES];
	logic signed [31:0] off_n [NUM_AXES];
	logic signed [31:0] nv_n [NUM_AXES];
	logic signed [31:0] orig_n [NUM_AXES];
	logic signed [31:0] op_n [NUM_AXES];
	logic [NUM_AXES-1:0] inc_n;
	logic signed [31:0] term_n [NUM_AXES];
	logic signed [31:0] color_n;

	// whole pipeline moves unless the output is blocked
	assign adv       = !(vld_q[NST-1] && out_stall);
	assign pop       = adv && din_valid;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NST-2:0], din_valid};
	end

	// divider steps, one quotient bit per stage
	always_comb begin
		logic [63:0] sh;
		logic        b;
		for (int k = 0; k < NUM_AXES; k++) begin
			b = (num_s2[k] >= den_s2[k]);
			rem_n[0][k] = b ? (num_s2[k] - den_s2[k]) : num_s2[k];
			q_n[0][k]   = QW'(b);
		end
		for (int j = 1; j < DST; j++) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				sh = rem_d[j-1][k] << 1;
				b  = (sh >= den_d[j-1][k]);
				rem_n[j][k] = b ? (sh - den_d[j-1][k]) : sh;
				q_n[j][k]   = {q_d[j-1][k][QW-2:0], b};
			end
		end
	end

	// multiply, offset and color arithmetic
	always_comb begin
		logic signed [31:0] c;
		logic signed [PW-1:0] cq;
		logic signed [63:0] tg;
		logic signed [63:0] a;
		logic signed [31:0] d;
		logic signed [47:0] fo;
		logic signed [47:0] fs;
		logic signed [31:0] acc;
		for (int k = 0; k < NUM_AXES; k++) begin
			c = $signed(cfg.offset[k]);
			// t = floor(c*q / 2^F)
			cq = c * $signed({1'b0, q_d[DST-1][k]});
			t_n[k] = 32'(cq >>> FRAC_BITS);
			// m = sat(floor(t*gain / 2^F))
			tg = t_m1[k] * $signed(cfg.gain);
			m_n[k] = sat32(tg >>> FRAC_BITS);
			// signed offset and new coordinate
			if (zf_m2[k] || !cfg.axis_en[k])
				off_n[k] = '0;
			else if (v_m2[k] < 0)
				off_n[k] = sat32(-64'(m_m2[k]));
			else
				off_n[k] = m_m2[k];
			nv_n[k] = cfg.axis_en[k] ? sat32(64'(v_m2[k]) + 64'(off_n[k])) : v_m2[k];
			orig_n[k] = v_m2[k];
			if (k == NUM_AXES - 1 && wz_m2)
				orig_n[k] = '0;
			// color operand
			a = (nv_m3[k] < 0) ? -64'(nv_m3[k]) : 64'(nv_m3[k]);
			d = sat32(a - 64'(c >>> 1));
			op_n[k]  = cfg.color_mode ? off_m3[k] : d;
			inc_n[k] = cfg.color_mode || (nv_m3[k] != orig_m3[k]);
			// color term
			fo = $signed(cfg.weight[k]) * op_c1[k];
			fs = fo >>> 8;
			term_n[k] = inc_c1[k] ? sat32(64'(fs)) : 32'sd0;
		end
		// saturating accumulation, x to w
		acc = $signed(color_c2);
		for (int k = 0; k < NUM_AXES; k++)
			acc = sat32(64'(acc) + 64'(term_c2[k]));
		color_n = cfg.color_en ? acc : $signed(color_c2);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				logic [31:0] ac;
				ac = cfg.offset[k][31] ? (32'd0 - cfg.offset[k]) : cfg.offset[k];
				// S1: squares
				v_s1[k]    <= $signed(din.pos[k]);
				num_s1[k]  <= din.mag[k] * din.mag[k];
				acsq_s1[k] <= ac * ac;
				// S2: denominator
				v_s2[k]   <= v_s1[k];
				num_s2[k] <= num_s1[k];
				den_s2[k] <= num_s1[k] + acsq_s1[k];
				zf_s2[k]  <= vz_s1[k] || ((num_s1[k] + acsq_s1[k]) == 64'd0);
			end
			vz_s1    <= din.is_zero;
			color_s1 <= din.color;
			wz_s1    <= din.w_zero;
			color_s2 <= color_s1;
			wz_s2    <= wz_s1;
			// divider
			for (int j = 0; j < DST; j++) begin
				for (int k = 0; k < NUM_AXES; k++) begin
					rem_d[j][k] <= rem_n[j][k];
					q_d[j][k]   <= q_n[j][k];
					den_d[j][k] <= (j == 0) ? den_s2[k] : den_d[j-1][k];
					v_d[j][k]   <= (j == 0) ? v_s2[k] : v_d[j-1][k];
				end
				zf_d[j]    <= (j == 0) ? zf_s2 : zf_d[j-1];
				color_d[j] <= (j == 0) ? color_s2 : color_d[j-1];
				wz_d[j]    <= (j == 0) ? wz_s2 : wz_d[j-1];
			end
			// multiplies, offset, color
			for (int k = 0; k < NUM_AXES; k++) begin
				t_m1[k]    <= t_n[k];
				v_m1[k]    <= v_d[DST-1][k];
				m_m2[k]    <= m_n[k];
				v_m2[k]    <= v_m1[k];
				off_m3[k]  <= off_n[k];
				nv_m3[k]   <= nv_n[k];
				orig_m3[k] <= orig_n[k];
				op_c1[k]   <= op_n[k];
				nv_c1[k]   <= nv_m3[k];
				term_c2[k] <= term_n[k];
				nv_c2[k]   <= nv_c1[k];
				nv_o_q[k]  <= nv_c2[k];
			end
			zf_m1     <= zf_d[DST-1];
			color_m1  <= color_d[DST-1];
			wz_m1     <= wz_d[DST-1];
			zf_m2     <= zf_m1;
			color_m2  <= color_m1;
			wz_m2     <= wz_m1;
			color_m3  <= color_m2;
			inc_c1    <= inc_n;
			color_c1  <= color_m3;
			color_c2  <= color_c1;
			color_o_q <= color_n;
		end
	end

	assign new_x     = nv_o_q[0];
	assign new_y     = nv_o_q[1];
	assign new_z     = nv_o_q[2];
	assign new_w     = nv_o_q[3];
	assign color_out = color_o_q;

endmodule
`default_nettype wire

/* rtl/core/soft_offset_s_curve_4d.sv */
// Top level of the soft offset S-curve 4D block: config port, front end,
// queue and back end. Depends on sosc_pkg, sosc_cfg, sosc_front, sosc_fifo, sosc_back.
//
//   channel   handshake                  payload
//   input     in_valid / in_stall        pos_x, pos_y, pos_z, pos_w, color_in
//   output    out_valid / out_stall      new_x, new_y, new_z, new_w, color_out
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata (64 bits)
//
// One point per cycle sustained while the output is not stalled. A point passes
// through the queue and then the back pipeline, whose depth is set by the
// one-bit-per-stage divider.
// A stall on the output freezes the back pipeline; the four-entry queue keeps
// taking points until it fills. Reset clears all control state and presets registers.
`default_nettype none
module soft_offset_s_curve_4d #(
	parameter int FRAC_BITS = sosc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sosc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sosc_pkg::PDATA_W-1:0] pwdata,
	output logic      [sosc_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [31:0]                  pos_x,
	input  wire logic [31:0]                  pos_y,
	input  wire logic [31:0]                  pos_z,
	input  wire logic [31:0]                  pos_w,
	input  wire logic [31:0]                  color_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [31:0]                       new_x,
	output logic [31:0]                       new_y,
	output logic [31:0]                       new_z,
	output logic [31:0]                       new_w,
	output logic [31:0]                       color_out
);
	import sosc_pkg::*;

	cfg_t  cfg;
	item_t push_item;
	item_t pop_item;
	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_not_empty;

	assign pready = 1'b1;

	sosc_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	sosc_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.pos_w    (pos_w),
		.color_in (color_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	sosc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.dout      (pop_item)
	);

	sosc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.din       (pop_item),
		.din_valid (q_not_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_x     (new_x),
		.new_y     (new_y),
		.new_z     (new_z),
		.new_w     (new_w),
		.color_out (color_out)
	);

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for soft_offset_s_curve_4d: drives points and register writes,
// predicts each transformed point and color, and checks results in order.
// Depends on sosc_pkg and the RTL top level.
`default_nettype none
module tb_top;
	import sosc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, pos_w = '0, color_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] new_x, new_y, new_z, new_w, color_out;

	typedef struct packed {
		logic [31:0] x, y, z, w, color;
	} point_t;

	// testbench copy of the registers
	logic signed [31:0] m_off [4];
	logic signed [31:0] m_gain;
	logic [5:0]         m_ctrl;
	logic [63:0]        m_wts;

	point_t expected_points[$];
	int     err_count = 0;
	int     idle_cycles = 0;
	bit     rx_idle_en = 1'b0;
	bit     tx_idle_en = 1'b0;
	bit     rx_hold = 1'b0;

	soft_offset_s_curve_4d u_top (.*);

	always #4 clk = ~clk;

	// clamp helper
	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// s-curve offset for one axis; >>> floors toward minus infinity
	function automatic logic signed [63:0] curve_off(input logic signed [63:0] v,
			input logic signed [63:0] c);
		logic [63:0] av, ac, num, den, q;
		logic [127:0] wq;
		logic signed [63:0] t, m;
		av = (v < 0) ? -v : v;
		ac = (c < 0) ? -c : c;
		num = av * av;
		den = num + ac * ac;
		if (den == 0 || v == 0) return 0;
		// numerator reaches 2^78, so divide at double width
		wq = (128'(num) << 16) / 128'(den);
		q = wq[63:0];
		t = (c * $signed(q)) >>> 16;
		m = clamp32((t * m_gain) >>> 16);
		return (v < 0) ? clamp32(-m) : m;
	endfunction

	function automatic point_t predict_point(input point_t p);
		logic signed [63:0] orig [4], cur [4], nv [4], off [4];
		logic signed [63:0] color, f, term, a, d;
		point_t r;
		orig[0] = $signed(p.x); orig[1] = $signed(p.y);
		orig[2] = $signed(p.z); orig[3] = $signed(p.w);
		color = $signed(p.color);
		for (int k = 0; k < 4; k++) cur[k] = orig[k];
		if (cur[3] == 0) cur[3] = -1;
		for (int k = 0; k < 4; k++) begin
			off[k] = 0;
			nv[k] = cur[k];
			if (m_ctrl[k]) begin
				off[k] = curve_off(cur[k], m_off[k]);
				nv[k] = clamp32(cur[k] + off[k]);
			end
		end
		if (m_ctrl[4]) begin
			for (int k = 0; k < 4; k++) begin
				f = $signed(m_wts[16*k +: 16]);
				if (m_ctrl[5]) begin
					term = clamp32((f * off[k]) >>> 8);
					color = clamp32(color + term);
				end else if (nv[k] != orig[k]) begin
					a = (nv[k] < 0) ? -nv[k] : nv[k];
					d = clamp32(a - (64'(m_off[k]) >>> 1));
					term = clamp32((f * d) >>> 8);
					color = clamp32(color + term);
				end
			end
		end
		r.x = nv[0][31:0]; r.y = nv[1][31:0]; r.z = nv[2][31:0];
		r.w = nv[3][31:0]; r.color = color[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_v);
		$display("mismatch %s: got %h expected %h", what, got, exp_v);
		err_count++;
	endtask

	// register write, setup then access phase; waits until nothing is in flight
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		while (expected_points.size() != 0) @(negedge clk);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = PADDR_W'(8 * int'(idx)); pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_OFFSET_X:      m_off[0] = val[31:0];
			REG_OFFSET_Y:      m_off[1] = val[31:0];
			REG_OFFSET_Z:      m_off[2] = val[31:0];
			REG_OFFSET_W:      m_off[3] = val[31:0];
			REG_GAIN:          m_gain = val[31:0];
			REG_CONTROL_BITS:  m_ctrl = val[5:0];
			REG_COLOR_WEIGHTS: m_wts = val;
			default: ;
		endcase
	endtask

	// one point transfer; starts and ends at a falling edge
	task automatic send_point(input point_t p);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		pos_x = p.x; pos_y = p.y; pos_z = p.z; pos_w = p.w; color_in = p.color;
		do @(posedge clk); while (in_stall);
		expected_points.push_back(predict_point(p));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (expected_points.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
			4, 5: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.x = rand_word(); p.y = rand_word(); p.z = rand_word();
		p.w = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_word();
		p.color = rand_word();
		return p;
	endfunction

	task automatic random_config();
		write_reg(REG_OFFSET_X, {32'h0, rand_word()});
		write_reg(REG_OFFSET_Y, {32'h0, rand_word()});
		write_reg(REG_OFFSET_Z, {32'h0, rand_word()});
		write_reg(REG_OFFSET_W, {32'h0, rand_word()});
		write_reg(REG_GAIN, {32'h0, rand_word()});
		write_reg(REG_CONTROL_BITS, 64'($urandom_range(0, 63)));
		write_reg(REG_COLOR_WEIGHTS, {$urandom, $urandom});
	endtask

	// extremes and special cases at reset and extreme settings
	task automatic test_directed();
		point_t p;
		p = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0};
		send_point(p);
		write_reg(REG_CONTROL_BITS, 64'h1f);
		write_reg(REG_COLOR_WEIGHTS, 64'h0100_ff00_7fff_8000);
		send_point('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
		write_reg(REG_OFFSET_X, 64'h0002_0000);
		write_reg(REG_OFFSET_Y, 64'h8000_0000);
		write_reg(REG_OFFSET_Z, 64'h7fff_ffff);
		write_reg(REG_OFFSET_W, 64'hffff_0000);
		send_point('{32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000, 32'h0, 32'h7fff_ffff});
		send_point('{32'h8000_0000, 32'h7fff_ffff, 32'hfffd_0000, 32'h1, 32'h8000_0000});
		send_point('{32'h0, 32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0});
		write_reg(REG_GAIN, 64'h7fff_ffff);
		send_point('{32'h4000_0000, 32'hc000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1});
		write_reg(REG_GAIN, 64'h8000_0000);
		send_point('{32'h4000_0000, 32'hc000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1});
		write_reg(REG_CONTROL_BITS, 64'h3f);
		send_point('{32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0, 32'h7fff_0000});
		send_point('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000});
		write_reg(REG_CONTROL_BITS, 64'h10);
		send_point('{32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0100_0000});
		write_reg(REG_CONTROL_BITS, 64'h0);
		send_point('{32'hdead_beef, 32'h0, 32'h0, 32'h0, 32'h5555_5555});
		drain();
	endtask

	// random content over several settings, with idling on both sides
	task automatic test_random();
		rx_idle_en = 1'b1; tx_idle_en = 1'b1;
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			repeat (40) send_point(rand_point());
			drain();
		end
	endtask

	// long output hold so the queue fills and stalls the input
	task automatic test_backpressure();
		rx_idle_en = 1'b0; tx_idle_en = 1'b0;
		write_reg(REG_CONTROL_BITS, 64'h3f);
		rx_hold = 1'b1;
		repeat (40) send_point(rand_point());
		drain();
	endtask

	// last part: no idling at all
	task automatic test_full_rate();
		rx_idle_en = 1'b0; tx_idle_en = 1'b0;
		random_config();
		repeat (60) send_point(rand_point());
		drain();
	endtask

	// output side stall driver
	always begin
		@(negedge clk);
		if (rx_hold) begin
			out_stall <= 1'b1;
			repeat (60) @(negedge clk);
			out_stall <= 1'b0;
			rx_hold = 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		point_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected result transfer", new_x, 32'h0);
			end else begin
				e = expected_points.pop_front();
				if (new_x !== e.x) report_mismatch("new_x", new_x, e.x);
				if (new_y !== e.y) report_mismatch("new_y", new_y, e.y);
				if (new_z !== e.z) report_mismatch("new_z", new_z, e.z);
				if (new_w !== e.w) report_mismatch("new_w", new_w, e.w);
				if (color_out !== e.color) report_mismatch("color_out", color_out, e.color);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		m_off[0] = 0; m_off[1] = 0; m_off[2] = 0; m_off[3] = 0;
		m_gain = 32'h0001_0000; m_ctrl = 6'h1; m_wts = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_full_rate();
		if (err_count == 0 && expected_points.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
